// ===== sv/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg: shared types and constants for the switch change reporter
// Opcodes, field widths, controller states and the command/status bundles
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scr_pkg;

    // Fixed payload field widths
    localparam int LEVEL_W = 16;
    localparam int CHAN_W  = 4;
    localparam int COUNT_W = 3;

    // Item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_SCAN   = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_sample;  // latch levels of enabled channels
        logic start_scan;   // clear the per-scan report count
        logic step;         // examine the channel under the cursor
        logic flush;        // push the final result of the item
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;    // output register can take a result this cycle
        logic scan_done;    // current step ends the scan
    } t_stat;

endpackage

`default_nettype wire

// ===== sv/scr_if.sv =====
// ----------------------------------------------------------------------------
// scr_if: channel interfaces for the switch change reporter
// Item input channel, result output channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface scr_in_if;
    import scr_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [LEVEL_W-1:0] levels;

    modport source (output valid, output opcode, output levels, input ready);
    modport sink   (input valid, input opcode, input levels, output ready);
endinterface

interface scr_out_if;
    import scr_pkg::*;
    logic               valid;
    logic               ready;
    logic               has_report;
    logic [CHAN_W-1:0]  channel;
    logic               pressed;
    logic [COUNT_W-1:0] report_count;
    logic               last;
    logic [LEVEL_W-1:0] switch_states;

    modport source (output valid, output has_report, output channel, output pressed,
                    output report_count, output last, output switch_states,
                    input ready);
    modport sink   (input valid, input has_report, input channel, input pressed,
                    input report_count, input last, input switch_states,
                    output ready);
endinterface

interface scr_cfg_if;
    import scr_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] channel_enable;

    modport source (output valid, output channel_enable, input ready);
    modport sink   (input valid, input channel_enable, output ready);
endinterface

`default_nettype wire

// ===== sv/scr_ctrl.sv =====
// ----------------------------------------------------------------------------
// scr_ctrl: sequencing controller for the switch change reporter
// Accepts one item at a time, steps a scan one channel per cycle while the
// output register can take a result, and schedules the final result push.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_ctrl
    import scr_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_item_valid,
    input  wire   i_item_opcode,
    input  t_stat i_stat,
    output logic  o_item_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    if (i_item_opcode == OP_SAMPLE) begin
                        o_cmd.load_sample = 1'b1;
                        n_state           = S_FLUSH;
                    end else begin
                        o_cmd.start_scan = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // one channel per cycle, only while a push can land
                if (i_stat.slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.scan_done) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (i_stat.slot_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/scr_datapath.sv =====
// ----------------------------------------------------------------------------
// scr_datapath: level storage, scan cursor and result register
// Holds latched and reported levels, the channel enable register, one
// pending report and the output result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_datapath
    import scr_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int MAX_REPORTS = 4
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [LEVEL_W-1:0] i_levels,
    input  wire                i_cfg_valid,
    input  wire  [LEVEL_W-1:0] i_cfg_data,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    scr_out_if.source          o_result
);

    localparam int CW   = $clog2(CHANNELS);
    localparam int CNTW = $clog2(MAX_REPORTS + 1);

    logic [CHANNELS-1:0] r_enable;
    logic [CHANNELS-1:0] r_cur;
    logic [CHANNELS-1:0] r_rep;
    logic [CW-1:0]       r_cursor;
    logic [CNTW-1:0]     r_count;

    logic                r_pend_valid;
    logic [CHAN_W-1:0]   r_pend_chan;
    logic                r_pend_pressed;
    logic [COUNT_W-1:0]  r_pend_count;

    logic                r_out_valid;
    logic                r_out_has;
    logic [CHAN_W-1:0]   r_out_chan;
    logic                r_out_pressed;
    logic [COUNT_W-1:0]  r_out_count;
    logic                r_out_last;
    logic [LEVEL_W-1:0]  r_out_states;

    logic [CHANNELS-1:0] lv_ext;
    logic [CHANNELS-1:0] en_ext;
    logic [LEVEL_W-1:0]  states;
    logic [CHAN_W-1:0]   cursor_chan;
    logic [COUNT_W-1:0]  count_inc_out;
    logic [CNTW-1:0]     count_inc;
    logic                at_end;
    logic                hit;
    logic                slot_free;
    logic                push_pend;

    // Width adaptation between the fixed fields and the channel count
    generate
        if (CHANNELS > LEVEL_W) begin : g_wide
            assign lv_ext = {{(CHANNELS - LEVEL_W){1'b0}}, i_levels};
            assign en_ext = {{(CHANNELS - LEVEL_W){1'b0}}, i_cfg_data};
        end else begin : g_narrow
            assign lv_ext = i_levels[CHANNELS-1:0];
            assign en_ext = i_cfg_data[CHANNELS-1:0];
        end
        if (CHANNELS >= LEVEL_W) begin : g_st_wide
            assign states = r_cur[LEVEL_W-1:0];
        end else begin : g_st_narrow
            assign states = {{(LEVEL_W - CHANNELS){1'b0}}, r_cur};
        end
        if (CW >= CHAN_W) begin : g_ch_wide
            assign cursor_chan = r_cursor[CHAN_W-1:0];
        end else begin : g_ch_narrow
            assign cursor_chan = {{(CHAN_W - CW){1'b0}}, r_cursor};
        end
        if (CNTW >= COUNT_W) begin : g_cnt_wide
            assign count_inc_out = count_inc[COUNT_W-1:0];
        end else begin : g_cnt_narrow
            assign count_inc_out = {{(COUNT_W - CNTW){1'b0}}, count_inc};
        end
    endgenerate

    // Scan step decode
    assign count_inc = r_count + 1'b1;
    assign at_end    = (r_cursor == CW'(CHANNELS - 1));
    assign hit       = r_enable[r_cursor] && (r_cur[r_cursor] != r_rep[r_cursor]);
    assign slot_free = !r_out_valid || o_result.ready;
    assign push_pend = i_cmd.step && hit && r_pend_valid;

    assign o_stat.slot_free = slot_free;
    assign o_stat.scan_done = at_end || (hit && (count_inc == CNTW'(MAX_REPORTS)));

    // Enable register, latched and reported levels, cursor and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_cur    <= '1;
            r_rep    <= '1;
            r_cursor <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= en_ext;
            end
            if (i_cmd.load_sample) begin
                r_cur <= (r_cur & ~r_enable) | (lv_ext & r_enable);
            end
            if (i_cmd.start_scan) begin
                r_count <= '0;
            end
            if (i_cmd.step) begin
                r_cursor <= at_end ? '0 : r_cursor + 1'b1;
                if (hit) begin
                    r_rep[r_cursor] <= r_cur[r_cursor];
                    r_count         <= count_inc;
                end
            end
        end
    end

    // Pending report: held until the next report or the end of the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.step && hit) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && hit) begin
            r_pend_chan    <= cursor_chan;
            r_pend_pressed <= !r_cur[r_cursor];
            r_pend_count   <= count_inc_out;
        end
    end

    // Output result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_pend || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_pend || (i_cmd.flush && r_pend_valid)) begin
            r_out_has     <= 1'b1;
            r_out_chan    <= r_pend_chan;
            r_out_pressed <= r_pend_pressed;
            r_out_count   <= r_pend_count;
            r_out_last    <= i_cmd.flush;
            r_out_states  <= states;
        end else if (i_cmd.flush) begin
            r_out_has     <= 1'b0;
            r_out_chan    <= '0;
            r_out_pressed <= 1'b0;
            r_out_count   <= '0;
            r_out_last    <= 1'b1;
            r_out_states  <= states;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.has_report    = r_out_has;
    assign o_result.channel       = r_out_chan;
    assign o_result.pressed       = r_out_pressed;
    assign o_result.report_count  = r_out_count;
    assign o_result.last          = r_out_last;
    assign o_result.switch_states = r_out_states;

endmodule

`default_nettype wire

// ===== sv/switch_change_reporter.sv =====
// ----------------------------------------------------------------------------
// switch_change_reporter: change-of-state scanner for switch channels
// Latches sampled switch levels and reports level changes per channel.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries one transaction per item: opcode sample latches the levels
//   of enabled channels, opcode scan walks the channels from a saved cursor
//   to the last one and reports each changed enabled channel, up to MAX_REPORTS per scan.
//   o_result delivers one transaction per report (or one empty result for a
//   sample or a scan without changes); last marks the final one of an item.
//   i_cfg writes the channel enable register; it is always ready, and the user must
//   write it only while the block is idle; the block itself does not enforce it.
//   A sample passes from IDLE to FLUSH, which pushes its result into the
//   output register. A scan visits one channel per cycle while the output
//   register can take a result, and FLUSH pushes its final result once the
//   scan ends.
//   Items are taken one at a time; the next one is accepted as soon as the
//   final result sits in the output register, even if it is not yet taken.
//   Reset sets all latched and reported levels high, the cursor to zero and
//   the enable register to zero. When the receiver stalls, the scan holds
//   and the output register keeps its transaction unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module switch_change_reporter
    import scr_pkg::*;
#(
    parameter int CHANNELS    = 16,
    parameter int MAX_REPORTS = 4
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    scr_in_if.sink    i_item,
    scr_out_if.source o_result,
    scr_cfg_if.sink   i_cfg
);

    t_cmd  cmd;
    t_stat stat;
    logic  item_ready;

    assign i_item.ready = item_ready;
    assign i_cfg.ready  = 1'b1;

    scr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (i_item.valid),
        .i_item_opcode (i_item.opcode),
        .i_stat        (stat),
        .o_item_ready  (item_ready),
        .o_cmd         (cmd)
    );

    scr_datapath #(
        .CHANNELS    (CHANNELS),
        .MAX_REPORTS (MAX_REPORTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_levels    (i_item.levels),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.channel_enable),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== sv/scr_checker.sv =====
// ----------------------------------------------------------------------------
// scr_checker: port-level assertions for the switch change reporter
// Checks result field consistency and output stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module scr_checker
    import scr_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               i_ready,
    input wire               i_has_report,
    input wire [CHAN_W-1:0]  i_channel,
    input wire               i_pressed,
    input wire [COUNT_W-1:0] i_report_count,
    input wire               i_last,
    input wire [LEVEL_W-1:0] i_switch_states
);

    // An empty result has zero fields and is the final result of its item
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_has_report) |->
            (i_channel == '0 && !i_pressed && i_report_count == '0 && i_last))
        else $error("empty result with nonzero fields or last low");

    // A report always counts itself
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_has_report) |-> (i_report_count != '0))
        else $error("report with zero report_count");

    // Pressed flag agrees with the latched level shown alongside it
    a_pressed_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_has_report) |-> (i_pressed == !i_switch_states[i_channel]))
        else $error("pressed flag disagrees with switch_states");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_has_report) && $stable(i_channel) &&
             $stable(i_pressed) && $stable(i_report_count) && $stable(i_last) &&
             $stable(i_switch_states)))
        else $error("result changed while stalled");

endmodule

bind switch_change_reporter scr_checker u_scr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_result.valid),
    .i_ready         (o_result.ready),
    .i_has_report    (o_result.has_report),
    .i_channel       (o_result.channel),
    .i_pressed       (o_result.pressed),
    .i_report_count  (o_result.report_count),
    .i_last          (o_result.last),
    .i_switch_states (o_result.switch_states)
);

`default_nettype wire
